// ===== hw/rtl/ptcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcc_pkg
// shared types, sizes and codes of the packet traffic classifier and counter
// ----------------------------------------------------------------------------
package ptcc_pkg;

    localparam int NUM_SLOTS      = 16;
    localparam int PORTS_PER_SLOT = 8;
    localparam int TABLE_SIZE     = NUM_SLOTS * PORTS_PER_SLOT;
    localparam int TBL_AW         = $clog2(TABLE_SIZE);
    localparam int SLOT_AW        = $clog2(NUM_SLOTS);

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 296;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // request codes
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    // result kinds
    localparam logic [1:0] RES_VERDICT  = 2'd0;
    localparam logic [1:0] RES_ACK      = 2'd1;
    localparam logic [1:0] RES_INTERVAL = 2'd2;
    localparam logic [1:0] RES_SLOT     = 2'd3;

    // traffic classes, also interval counter index for the first four
    localparam logic [2:0] CLS_TOTAL = 3'd0;
    localparam logic [2:0] CLS_TCP   = 3'd1;
    localparam logic [2:0] CLS_UDP   = 3'd2;
    localparam logic [2:0] CLS_ICMP  = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       count;
        logic       scan_start;
        logic       scan_step;
        logic       credit;
        logic       write_tbl;
        logic       load_out;
        logic [1:0] out_kind;
        logic [1:0] tick_idx;
        logic       clear_int;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       is_tcp;
        logic       scan_last;
        logic       out_free;
    } t_sts;

    // unit code by 1024 steps
    function automatic logic [1:0] unit_of(input logic [63:0] b);
        logic [1:0] u;
        if (|b[63:30])      u = 2'd3;
        else if (|b[29:20]) u = 2'd2;
        else if (|b[19:10]) u = 2'd1;
        else                u = 2'd0;
        return u;
    endfunction

endpackage

// ===== hw/rtl/packet_traffic_classifier_counter.sv =====
// ----------------------------------------------------------------------------
// packet_traffic_classifier_counter
// per-class interval traffic counters with tcp port to process slot accounting
// ----------------------------------------------------------------------------
// requests come in on the s_axis channel, tuser selecting packet, port entry
// write, interval tick or slot read; results leave on m_axis with tuser giving
// the result kind and tlast marking the final result of a request.
// one request is handled at a time. a tcp packet scans the 128-entry port
// table, one entry per cycle through the table memory's single read port,
// in the scan state, then passes the drain and credit states before its
// result is loaded in the emit state; other requests go from decode
// straight to emit, and a tick loads its four results from the tick state.
// results sit in an output register; a new request is accepted while a result
// waits there, and the block stalls before loading the next result until the
// receiver takes the previous one.
// reset clears all counters, slot totals and process ids and marks every port
// entry invalid; it needs no clearing pass.
// ----------------------------------------------------------------------------
module packet_traffic_classifier_counter import ptcc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frame_length, ether_type, ip_protocol, src port, dst port, slot,
    // port_index, port_value, entry_valid, process_id, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // traffic_class, byte_count, packet_count, rate_unit, matched,
    // matched_slot, outgoing, slot_process_id, send_total, receive_total, pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    ptcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptcc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/ptcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptcc_ctrl
// sequencer: decodes one request, runs the port table scan, emits results
// ----------------------------------------------------------------------------
module ptcc_ctrl import ptcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_CREDIT = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_TICK   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_tick, n_tick;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_tick  = r_tick;
        o_cmd   = '0;
        o_cmd.tick_idx = r_tick;
        o_cmd.out_kind = i_sts.req_type;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.req_type)
                    REQ_PACKET: begin
                        o_cmd.count = 1'b1;
                        if (i_sts.is_tcp) begin
                            o_cmd.scan_start = 1'b1;
                            n_state = ST_SCAN;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                    REQ_WRITE: begin
                        o_cmd.write_tbl = 1'b1;
                        n_state = ST_EMIT;
                    end
                    REQ_TICK: begin
                        n_tick  = '0;
                        n_state = ST_TICK;
                    end
                    default: n_state = ST_EMIT;
                endcase
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = ST_CREDIT;
            ST_CREDIT: begin
                o_cmd.credit = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                o_cmd.out_kind = RES_INTERVAL;
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_tick = r_tick + 2'd1;
                    if (r_tick == 2'd3) begin
                        o_cmd.clear_int = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tick  <= '0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
        end
    end

endmodule

// ===== hw/rtl/ptcc_dp.sv =====
// ----------------------------------------------------------------------------
// ptcc_dp
// datapath: request register, counters, port table, slot counters, result reg
// ----------------------------------------------------------------------------
module ptcc_dp import ptcc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_req_type,
    input  logic [IN_DATA_W-1:0]  i_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [1:0]            o_out_kind,
    output logic                  o_out_last,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // captured request
    logic [1:0]  r_req;
    logic [15:0] r_len, r_etype, r_sport, r_dport, r_pval;
    logic [7:0]  r_proto;
    logic [3:0]  r_slot;
    logic [2:0]  r_pidx;
    logic        r_evalid;
    logic [22:0] r_pid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= REQ_PACKET;
        end else if (i_cmd.capture) begin
            r_req <= i_req_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_len    <= i_data[15:0];
            r_etype  <= i_data[31:16];
            r_proto  <= i_data[39:32];
            r_sport  <= i_data[55:40];
            r_dport  <= i_data[71:56];
            r_slot   <= i_data[75:72];
            r_pidx   <= i_data[78:76];
            r_pval   <= i_data[94:79];
            r_evalid <= i_data[95];
            r_pid    <= i_data[118:96];
        end
    end

    logic       w_ipv4;
    logic [2:0] w_class;
    logic       w_slot_ok, w_wr_ok;

    assign w_ipv4 = (r_etype == ETHERTYPE_IPV4);

    always_comb begin
        if (!w_ipv4)                  w_class = CLS_TOTAL;
        else if (r_proto == PROTO_TCP)  w_class = CLS_TCP;
        else if (r_proto == PROTO_UDP)  w_class = CLS_UDP;
        else if (r_proto == PROTO_ICMP) w_class = CLS_ICMP;
        else                          w_class = CLS_OTHER;
    end

    assign w_slot_ok = (32'(r_slot) < NUM_SLOTS);
    assign w_wr_ok   = w_slot_ok && (32'(r_pidx) < PORTS_PER_SLOT);

    // interval counters: index 0 total, 1 tcp, 2 udp, 3 icmp
    logic [63:0] r_int_bytes [4];
    logic [63:0] r_int_pkts  [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_int) begin
            for (int k = 0; k < 4; k++) begin
                r_int_bytes[k] <= '0;
                r_int_pkts[k]  <= '0;
            end
        end else if (i_cmd.count) begin
            for (int k = 0; k < 4; k++) begin
                if (k == 0 || 3'(k) == w_class) begin
                    r_int_bytes[k] <= r_int_bytes[k] + 64'(r_len);
                    r_int_pkts[k]  <= r_int_pkts[k] + 64'd1;
                end
            end
        end
    end

    // port table: port numbers in a memory, valid bits in flops
    logic [15:0]           r_tbl [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_tbl_vld;
    logic [TBL_AW-1:0]     w_waddr;
    logic [TBL_AW-1:0]     r_scan_addr;
    logic [15:0]           r_rd_port;
    logic                  r_rd_vld;
    logic                  r_cmp_en;
    logic [SLOT_AW-1:0]    r_cmp_slot;

    assign w_waddr = TBL_AW'(32'(r_slot) * PORTS_PER_SLOT + 32'(r_pidx));

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_tbl && w_wr_ok) r_tbl[w_waddr] <= r_pval;
        r_rd_port  <= r_tbl[r_scan_addr];
        r_rd_vld   <= r_tbl_vld[r_scan_addr];
        r_cmp_slot <= SLOT_AW'(32'(r_scan_addr) / PORTS_PER_SLOT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (i_cmd.write_tbl && w_wr_ok) begin
            r_tbl_vld[w_waddr] <= r_evalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_cmp_en    <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan_step;
            if (i_cmd.scan_start)     r_scan_addr <= '0;
            else if (i_cmd.scan_step) r_scan_addr <= r_scan_addr + TBL_AW'(1);
        end
    end

    // first source match and first destination match over the scan
    logic               r_src_hit, r_dst_hit;
    logic [SLOT_AW-1:0] r_src_slot, r_dst_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.capture) begin
            r_src_hit  <= 1'b0;
            r_dst_hit  <= 1'b0;
            r_src_slot <= '0;
            r_dst_slot <= '0;
        end else if (r_cmp_en && r_rd_vld) begin
            if (!r_src_hit && r_rd_port == r_sport) begin
                r_src_hit  <= 1'b1;
                r_src_slot <= r_cmp_slot;
            end
            if (!r_dst_hit && r_rd_port == r_dport) begin
                r_dst_hit  <= 1'b1;
                r_dst_slot <= r_cmp_slot;
            end
        end
    end

    logic               w_match, w_out_dir;
    logic [SLOT_AW-1:0] w_mslot;

    assign w_match   = r_src_hit || r_dst_hit;
    assign w_out_dir = r_src_hit;
    assign w_mslot   = r_src_hit ? r_src_slot : r_dst_slot;

    // per-slot process id and byte totals
    logic [22:0] r_slot_pid  [NUM_SLOTS];
    logic [63:0] r_slot_send [NUM_SLOTS];
    logic [63:0] r_slot_recv [NUM_SLOTS];
    logic [SLOT_AW-1:0] w_sidx;

    assign w_sidx = i_cmd.credit ? w_mslot : SLOT_AW'(r_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_slot_pid[s]  <= '0;
                r_slot_send[s] <= '0;
                r_slot_recv[s] <= '0;
            end
        end else if (i_cmd.write_tbl && w_wr_ok) begin
            r_slot_pid[w_sidx] <= r_pid;
        end else if (i_cmd.credit && w_match) begin
            if (w_out_dir) r_slot_send[w_sidx] <= r_slot_send[w_sidx] + 64'(r_len);
            else           r_slot_recv[w_sidx] <= r_slot_recv[w_sidx] + 64'(r_len);
        end
    end

    // result register
    logic                  r_out_valid;
    logic [1:0]            r_out_kind;
    logic                  r_out_last;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] w_res;
    logic [63:0]           w_tb, w_tp;

    assign w_tb = r_int_bytes[i_cmd.tick_idx];
    assign w_tp = r_int_pkts[i_cmd.tick_idx];

    always_comb begin
        w_res = '0;
        case (i_cmd.out_kind)
            RES_VERDICT: begin
                w_res[2:0]     = w_class;
                w_res[133]     = w_match;
                w_res[137:134] = w_match ? 4'(w_mslot) : 4'd0;
                w_res[138]     = w_match && w_out_dir;
            end
            RES_ACK: w_res[137:134] = r_slot;
            RES_INTERVAL: begin
                w_res[2:0]     = 3'(i_cmd.tick_idx);
                w_res[66:3]    = w_tb;
                w_res[130:67]  = w_tp;
                w_res[132:131] = unit_of(w_tb);
            end
            default: begin
                w_res[137:134] = r_slot;
                if (w_slot_ok) begin
                    w_res[161:139] = r_slot_pid[w_sidx];
                    w_res[225:162] = r_slot_send[w_sidx];
                    w_res[289:226] = r_slot_recv[w_sidx];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_data <= w_res;
            r_out_last <= (i_cmd.out_kind != RES_INTERVAL) || (i_cmd.tick_idx == 2'd3);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = r_out_data;

    assign o_sts.req_type  = r_req;
    assign o_sts.is_tcp    = w_ipv4 && (r_proto == PROTO_TCP);
    assign o_sts.scan_last = (32'(r_scan_addr) == TABLE_SIZE - 1);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level regression of the packet traffic classifier and counter
// ----------------------------------------------------------------------------
// requests go in one item at a time under varying sender and receiver idling;
// a local copy of the counters, port table and slot totals predicts every
// result, and each accepted result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ptcc_pkg::*;

    localparam int RES_BITS = 290;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] len;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  slot;
        logic [2:0]  pidx;
        logic [15:0] pval;
        logic        valid;
        logic [22:0] pid;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  cls;
        logic [63:0] bytes;
        logic [63:0] pkts;
        logic [1:0]  unit;
        logic        matched;
        logic [3:0]  mslot;
        logic        outgoing;
        logic [22:0] spid;
        logic [63:0] send;
        logic [63:0] recv;
        logic        last;
    } t_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // len, etype, proto, sport, dport, slot, pidx, pval, valid, pid
    logic [1:0]            s_axis_tuser;   // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // cls, bytes, pkts, unit, matched, mslot, out, pid, send, recv
    logic [1:0]            m_axis_tuser;   // result_kind
    logic                  m_axis_tlast;

    packet_traffic_classifier_counter uut (.*);

    // local copy of the block state
    logic [63:0] cnt_bytes [4];
    logic [63:0] cnt_pkts [4];
    logic [16:0] port_tbl [TABLE_SIZE];
    logic [22:0] pids [NUM_SLOTS];
    logic [63:0] send_bytes [NUM_SLOTS];
    logic [63:0] recv_bytes [NUM_SLOTS];

    t_res pending_results [$];
    int   fail_count;
    int   result_count;
    int   sent_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int lookup_port(input logic [15:0] port);
        for (int s = 0; s < NUM_SLOTS; s++)
            for (int p = 0; p < PORTS_PER_SLOT; p++)
                if (port_tbl[s * PORTS_PER_SLOT + p] == {1'b1, port}) return s;
        return -1;
    endfunction

    function automatic logic [1:0] size_unit(input logic [63:0] b);
        if (b >= 64'd1 << 30) return 2'd3;
        if (b >= 64'd1 << 20) return 2'd2;
        if (b >= 64'd1 << 10) return 2'd1;
        return 2'd0;
    endfunction

    task automatic expect_result(input t_res o);
        pending_results = {pending_results, o};
    endtask

    task automatic account_request(input t_req r);
        t_res o;
        int   s;
        o = '0;
        o.last = 1'b1;
        case (r.req)
            REQ_PACKET: begin
                o.kind = RES_VERDICT;
                o.cls  = CLS_TOTAL;
                cnt_bytes[0] += r.len;
                cnt_pkts[0]  += 1;
                if (r.etype == ETHERTYPE_IPV4) begin
                    if (r.proto == PROTO_ICMP) begin
                        o.cls = CLS_ICMP;
                    end else if (r.proto == PROTO_TCP) begin
                        o.cls = CLS_TCP;
                        s = lookup_port(r.sport);
                        if (s >= 0) begin
                            send_bytes[s] += r.len;
                            o.matched = 1'b1; o.mslot = 4'(s); o.outgoing = 1'b1;
                        end else begin
                            s = lookup_port(r.dport);
                            if (s >= 0) begin
                                recv_bytes[s] += r.len;
                                o.matched = 1'b1; o.mslot = 4'(s);
                            end
                        end
                    end else if (r.proto == PROTO_UDP) begin
                        o.cls = CLS_UDP;
                    end else begin
                        o.cls = CLS_OTHER;
                    end
                    if (o.cls != CLS_OTHER) begin
                        cnt_bytes[o.cls] += r.len;
                        cnt_pkts[o.cls]  += 1;
                    end
                end
                expect_result(o);
            end
            REQ_WRITE: begin
                port_tbl[r.slot * PORTS_PER_SLOT + r.pidx] = {r.valid, r.pval};
                pids[r.slot] = r.pid;
                o.kind  = RES_ACK;
                o.mslot = r.slot;
                expect_result(o);
            end
            REQ_TICK: begin
                for (int k = 0; k < 4; k++) begin
                    o = '0;
                    o.kind  = RES_INTERVAL;
                    o.cls   = 3'(k);
                    o.bytes = cnt_bytes[k];
                    o.pkts  = cnt_pkts[k];
                    o.unit  = size_unit(cnt_bytes[k]);
                    o.last  = (k == 3);
                    cnt_bytes[k] = '0;
                    cnt_pkts[k]  = '0;
                    expect_result(o);
                end
            end
            default: begin
                o.kind  = RES_SLOT;
                o.mslot = r.slot;
                o.spid  = pids[r.slot];
                o.send  = send_bytes[r.slot];
                o.recv  = recv_bytes[r.slot];
                expect_result(o);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // valid stays high between back to back items and drops only while idling or draining
    task automatic send_item(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req;
        s_axis_tdata  <= {1'b0, r.pid, r.valid, r.pval, r.pidx, r.slot, r.dport,
                          r.sport, r.proto, r.etype, r.len};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        account_request(r);
        sent_count++;
    endtask

    // receiver stall and result checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_res w;
                t_res g;
                g.kind = m_axis_tuser;
                g.last = m_axis_tlast;
                {g.recv, g.send, g.spid, g.outgoing, g.mslot, g.matched, g.unit,
                 g.pkts, g.bytes, g.cls} = m_axis_tdata[RES_BITS-1:0];
                result_count++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(g.kind), 64'd0);
                end else begin
                    w = pending_results.pop_front();
                    if (g.kind != w.kind) report_mismatch("kind", g.kind, w.kind);
                    if (g.cls != w.cls) report_mismatch("class", g.cls, w.cls);
                    if (g.bytes != w.bytes) report_mismatch("bytes", g.bytes, w.bytes);
                    if (g.pkts != w.pkts) report_mismatch("packets", g.pkts, w.pkts);
                    if (g.unit != w.unit) report_mismatch("unit", g.unit, w.unit);
                    if (g.matched != w.matched)
                        report_mismatch("matched", g.matched, w.matched);
                    if (g.mslot != w.mslot) report_mismatch("slot", g.mslot, w.mslot);
                    if (g.outgoing != w.outgoing)
                        report_mismatch("outgoing", g.outgoing, w.outgoing);
                    if (g.spid != w.spid) report_mismatch("pid", g.spid, w.spid);
                    if (g.send != w.send) report_mismatch("send", g.send, w.send);
                    if (g.recv != w.recv) report_mismatch("receive", g.recv, w.recv);
                    if (g.last != w.last) report_mismatch("last", g.last, w.last);
                    if (m_axis_tdata[OUT_DATA_W-1:RES_BITS] != '0)
                        report_mismatch("pad", 64'(m_axis_tdata[OUT_DATA_W-1:RES_BITS]),
                                        64'd0);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_req make_packet(input logic [15:0] len, input logic [15:0] et,
                                         input logic [7:0] pr, input logic [15:0] sp,
                                         input logic [15:0] dp);
        t_req r;
        r = t_req'({$urandom, $urandom, $urandom, $urandom});
        r.req = REQ_PACKET; r.len = len; r.etype = et; r.proto = pr;
        r.sport = sp; r.dport = dp;
        return r;
    endfunction

    function automatic t_req make_write(input logic [3:0] s, input logic [2:0] pi,
                                        input logic [15:0] pv, input logic v,
                                        input logic [22:0] pid);
        t_req r;
        r = t_req'({$urandom, $urandom, $urandom, $urandom});
        r.req = REQ_WRITE; r.slot = s; r.pidx = pi; r.pval = pv; r.valid = v;
        r.pid = pid;
        return r;
    endfunction

    function automatic t_req make_other(input logic [1:0] kind, input logic [3:0] s);
        t_req r;
        r = t_req'({$urandom, $urandom, $urandom, $urandom});
        r.req = kind; r.slot = s;
        return r;
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(make_other(REQ_READ, 4'd15));
        send_item(make_other(REQ_TICK, 4'd0));
        send_item(make_write(4'd0, 3'd0, 16'd80, 1'b1, 23'h7fffff));
        send_item(make_write(4'd15, 3'd7, 16'hffff, 1'b1, 23'd0));
        send_item(make_write(4'd3, 3'd2, 16'd80, 1'b1, 23'h2aaaaa));
        send_item(make_write(4'd5, 3'd4, 16'd0, 1'b0, 23'h555555));
        send_item(make_packet(16'hffff, ETHERTYPE_IPV4, PROTO_TCP, 16'd80, 16'd1));
        send_item(make_packet(16'd1, ETHERTYPE_IPV4, PROTO_TCP, 16'd9, 16'hffff));
        send_item(make_packet(16'd0, ETHERTYPE_IPV4, PROTO_TCP, 16'd0, 16'd0));
        send_item(make_packet(16'd100, ETHERTYPE_IPV4, PROTO_UDP, 16'd80, 16'd0));
        send_item(make_packet(16'd1023, ETHERTYPE_IPV4, PROTO_ICMP, 16'd0, 16'd0));
        send_item(make_packet(16'd1024, ETHERTYPE_IPV4, 8'hff, 16'd0, 16'd0));
        send_item(make_packet(16'hffff, 16'hffff, PROTO_TCP, 16'd80, 16'd0));
        send_item(make_packet(16'd7, 16'h0000, 8'h00, 16'd0, 16'd0));
        send_item(make_other(REQ_READ, 4'd0));
        send_item(make_other(REQ_READ, 4'd15));
        send_item(make_other(REQ_READ, 4'd5));
        send_item(make_other(REQ_TICK, 4'd0));
        // clear an entry and check that slot 3 takes the match
        send_item(make_write(4'd0, 3'd0, 16'd80, 1'b0, 23'd1));
        send_item(make_packet(16'd3, ETHERTYPE_IPV4, PROTO_TCP, 16'd80, 16'd0));
        send_item(make_other(REQ_READ, 4'd3));
        send_item(make_other(REQ_TICK, 4'd0));
    endtask

    // push the interval counter past the first two unit thresholds
    task automatic test_units();
        for (int i = 0; i < 18; i++)
            send_item(make_packet(16'hffff, ETHERTYPE_IPV4, PROTO_UDP, 16'd0, 16'd0));
        send_item(make_other(REQ_TICK, 4'd0));
    endtask

    // ports drawn from a small pool so lookups hit often
    task automatic test_random(input int n);
        t_req r;
        logic [15:0] pool [8] = '{16'd22, 16'd80, 16'd443, 16'd0, 16'hffff,
                                  16'd8080, 16'd53, 16'h8000};
        for (int i = 0; i < n; i++) begin
            int pick;
            pick = $urandom_range(99);
            r = t_req'({$urandom, $urandom, $urandom, $urandom});
            if (pick < 55) begin
                r.req = REQ_PACKET;
                if ($urandom_range(3) != 0) r.etype = ETHERTYPE_IPV4;
                if ($urandom_range(3) != 0) r.proto = PROTO_TCP;
                else if ($urandom_range(1)) r.proto = PROTO_UDP;
                else if ($urandom_range(1)) r.proto = PROTO_ICMP;
                if ($urandom_range(4) != 0) r.sport = pool[$urandom_range(7)];
                if ($urandom_range(4) != 0) r.dport = pool[$urandom_range(7)];
                if ($urandom_range(3) == 0) r.len = 16'($urandom_range(64, 1500));
            end else if (pick < 75) begin
                r.req = REQ_WRITE;
                if ($urandom_range(3) != 0) r.pval = pool[$urandom_range(7)];
            end else if (pick < 85) begin
                r.req = REQ_TICK;
            end else begin
                r.req = REQ_READ;
            end
            send_item(r);
        end
    endtask

    initial begin
        fail_count     = 0;
        result_count   = 0;
        sent_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pending_results.delete();
        for (int k = 0; k < 4; k++) begin
            cnt_bytes[k] = '0;
            cnt_pkts[k]  = '0;
        end
        foreach (port_tbl[i]) port_tbl[i] = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            pids[s] = '0; send_bytes[s] = '0; recv_bytes[s] = '0;
        end
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PACKET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_units();
        test_random(105);
        wait_drained();
        send_idle_pct = 62;
        test_random(105);
        send_idle_pct = 0; recv_stall_pct = 62;
        test_random(105);
        send_idle_pct = 30; recv_stall_pct = 30;
        test_random(105);
        for (int s = 0; s < NUM_SLOTS; s++) send_item(make_other(REQ_READ, 4'(s)));

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("sent %0d requests of every kind, %0d results checked",
                 sent_count, result_count);
        $display("idling phases: none, sender, receiver, both");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
